// ===== src/bounded_linked_list_engine_defines.svh =====
// assertion macros for the bounded linked list engine checker
// sampled on clock, disabled while reset is high; no other dependencies
`ifndef BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BLLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define BLLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/blle_pkg.sv =====
// shared types and constants of the bounded linked list engine
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package blle_pkg;

   localparam int OP_W       = 3;
   localparam int VAL_W      = 32;
   localparam int IDX_W      = 8;
   localparam int ST_W       = 2;
   localparam int LEN_W      = 9;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [ST_W-1:0] ST_BOUNDS = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_ACCEPT     = 4'd1,
      ACT_WALK_INIT  = 4'd2,
      ACT_WALK_STEP  = 4'd3,
      ACT_FETCH      = 4'd4,
      ACT_LOAD       = 4'd5,
      ACT_APPEND_A   = 4'd6,
      ACT_APPEND_B   = 4'd7,
      ACT_FIX_FIRST  = 4'd8,
      ACT_FIX_LAST   = 4'd9,
      ACT_FIX_MID    = 4'd10,
      ACT_RELEASE    = 4'd11
   } blle_act_type;

   typedef enum logic [1:0] {
      POS_ZERO  = 2'd0,
      POS_INDEX = 2'd1,
      POS_LAST  = 2'd2
   } blle_pos_type;

   typedef struct packed {
      blle_act_type      act;
      logic              set_status;
      logic [ST_W-1:0]   status_code;
      blle_pos_type      pos_sel;
      logic              out_load;
   } blle_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            oob;
      logic            idx_zero;
      logic            idx_last;
      logic            multi;
      logic            walk_zero;
      logic            walk_last;
      logic            out_busy;
   } blle_stat_type;

endpackage

// ===== src/bounded_linked_list_engine.sv =====
// Errors and unused op codes go from decode straight to the result; append writes the entry
// and links the new slot; read and delete walk to the position, fetch and load the entry,
// and a delete then fixes the links where needed and releases the slot. The walk follows one
// link per cycle through the read port of the link memory; a new request is taken only once the result beat is loaded.
// Reset (synchronous) clears the list pointers and handshake state; no memory clearing
// pass is needed, untouched link slots are covered by a fill mark.
`timescale 1ns / 1ps

module bounded_linked_list_engine import blle_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value[31:0], index[39:32]
   input  logic [OP_W-1:0]       req_tuser,  // op[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // entry_value[31:0], length[40:32], zero pad
   output logic [ST_W-1:0]       rsp_tuser   // status[1:0]
);

   blle_cmd_type  cmd;
   blle_stat_type stat;

   blle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   blle_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/blle_ram.sv =====
// generic single-port-write, single-port-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module blle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/blle_datapath.sv =====
// datapath: list pointers, walk cursor, link and entry memories, result register
// depends on blle_pkg and blle_ram; driven by blle_ctrl through blle_cmd_type
`timescale 1ns / 1ps

module blle_datapath import blle_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  blle_cmd_type          cmd,
   output blle_stat_type         stat,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [ST_W-1:0]       rsp_tuser
);

   localparam int SW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

   // control state
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [SW-1:0] free_ff, free_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic [SW-1:0]           cursor_ff, cursor_in;
   logic [SW-1:0]           prev_ff, prev_in;
   logic [SW-1:0]           nxt_ff, nxt_in;
   logic [CW-1:0]           remain_ff, remain_in;
   logic signed [VAL_W-1:0] result_ff, result_in;
   logic [ST_W-1:0]         status_ff, status_in;
   logic                    unwritten_ff, unwritten_in;
   logic [SW-1:0]           inc_ff, inc_in;
   logic [ST_W-1:0]         rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [SW-1:0]    link_raddr, link_q, link_rd;
   logic             link_we;
   logic [SW-1:0]    link_waddr, link_wdata;
   logic             entry_we;
   logic [VAL_W-1:0] entry_q;
   logic [CW-1:0]    pos;

   blle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_q)
   );

   blle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (free_ff),
      .wr_data (value_ff),
      .rd_addr (cursor_ff),
      .rd_data (entry_q)
   );

   // slots at or above the fill mark were never linked: they still point to the next slot
   assign link_rd = unwritten_ff ? inc_ff : link_q;

   always_comb begin
      case (cmd.act)
         ACT_WALK_INIT: link_raddr = head_ff;
         ACT_WALK_STEP: link_raddr = link_rd;
         ACT_APPEND_A:  link_raddr = free_ff;
         default:       link_raddr = cursor_ff;
      endcase
   end

   always_comb begin
      link_we    = 1'b0;
      link_waddr = cursor_ff;
      link_wdata = free_ff;
      case (cmd.act)
         ACT_APPEND_A: begin
            link_we    = (count_ff != '0);
            link_waddr = tail_ff;
            link_wdata = free_ff;
         end
         ACT_APPEND_B: begin
            link_we    = 1'b1;
            link_waddr = free_ff;
            link_wdata = (count_ff == '0) ? free_ff : head_ff;
         end
         ACT_FIX_FIRST: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = nxt_ff;
         end
         ACT_FIX_LAST: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = head_ff;
         end
         ACT_FIX_MID: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = nxt_ff;
         end
         ACT_RELEASE: begin
            link_we    = 1'b1;
            link_waddr = cursor_ff;
            link_wdata = free_ff;
         end
         default: begin
            link_we = 1'b0;
         end
      endcase
   end

   assign entry_we = (cmd.act == ACT_APPEND_A);

   always_comb begin
      case (cmd.pos_sel)
         POS_INDEX: pos = CW'(index_ff);
         POS_LAST:  pos = count_ff - CW'(1);
         default:   pos = '0;
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      cursor_in    = cursor_ff;
      prev_in      = prev_ff;
      nxt_in       = nxt_ff;
      remain_in    = remain_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      unwritten_in = (CW'(link_raddr) >= fresh_ff);
      inc_in       = (link_raddr == SW'(CAPACITY - 1)) ? '0 : link_raddr + SW'(1);

      case (cmd.act)
         ACT_ACCEPT: begin
            op_in     = req_tuser;
            value_in  = req_tdata[VAL_W-1:0];
            index_in  = req_tdata[VAL_W+IDX_W-1:VAL_W];
            result_in = '0;
            status_in = ST_OK;
         end
         ACT_WALK_INIT: begin
            cursor_in = head_ff;
            remain_in = pos;
         end
         ACT_WALK_STEP: begin
            prev_in   = cursor_ff;
            cursor_in = link_rd;
            remain_in = remain_ff - CW'(1);
         end
         ACT_LOAD: begin
            nxt_in    = link_rd;
            result_in = entry_q;
         end
         ACT_APPEND_B: begin
            if (count_ff == '0) begin
               head_in = free_ff;
            end
            tail_in  = free_ff;
            free_in  = link_rd;
            count_in = count_ff + CW'(1);
            if (unwritten_ff) begin
               fresh_in = fresh_ff + CW'(1);
            end
         end
         ACT_FIX_FIRST: begin
            head_in = nxt_ff;
         end
         ACT_FIX_LAST: begin
            tail_in = prev_ff;
         end
         ACT_RELEASE: begin
            free_in  = cursor_ff;
            count_in = count_ff - CW'(1);
         end
         default: begin
            head_in = head_ff;
         end
      endcase

      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = status_ff;
         rsp_data_in  = {{(RSP_DATA_W - LEN_W - VAL_W){1'b0}}, LEN_W'(count_ff), result_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      index_ff     <= index_in;
      cursor_ff    <= cursor_in;
      prev_ff      <= prev_in;
      nxt_ff       <= nxt_in;
      remain_ff    <= remain_in;
      result_ff    <= result_in;
      status_ff    <= status_in;
      unwritten_ff <= unwritten_in;
      inc_ff       <= inc_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      stat.op        = op_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.oob       = (CMP_W'(index_ff) >= CMP_W'(count_ff));
      stat.idx_zero  = (index_ff == '0);
      stat.idx_last  = (CMP_W'(index_ff) == CMP_W'(count_ff - CW'(1)));
      stat.multi     = (count_ff > CW'(1));
      stat.walk_zero = (remain_ff == '0);
      stat.walk_last = (remain_ff == CW'(1));
      stat.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== src/blle_ctrl.sv =====
// controller: sequences each operation as datapath actions
// depends on blle_pkg; talks to blle_datapath through blle_cmd_type / blle_stat_type
`timescale 1ns / 1ps

module blle_ctrl import blle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  blle_stat_type stat,
   output blle_cmd_type  cmd
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_DECODE   = 11'b000_0000_0010,
      S_APPEND_A = 11'b000_0000_0100,
      S_APPEND_B = 11'b000_0000_1000,
      S_WALK     = 11'b000_0001_0000,
      S_FETCH    = 11'b000_0010_0000,
      S_LOAD     = 11'b000_0100_0000,
      S_FIX      = 11'b000_1000_0000,
      S_RELEASE  = 11'b001_0000_0000,
      S_DONE     = 11'b010_0000_0000,
      S_SPARE    = 11'b100_0000_0000
   } blle_state_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_FIRST = 2'd1,
      KIND_LAST  = 2'd2,
      KIND_MID   = 2'd3
   } blle_kind_type;

   blle_state_type state_ff, state_in;
   blle_kind_type  kind_ff, kind_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      cmd.act         = ACT_NONE;
      cmd.set_status  = 1'b0;
      cmd.status_code = ST_OK;
      cmd.pos_sel     = POS_ZERO;
      cmd.out_load    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.act  = ACT_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (stat.op)
               OP_APPEND: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     state_in = S_APPEND_A;
                  end
               end
               OP_DEL_FIRST: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.act  = ACT_WALK_INIT;
                     kind_in  = KIND_FIRST;
                     state_in = S_WALK;
                  end
               end
               OP_DEL_LAST: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.act     = ACT_WALK_INIT;
                     cmd.pos_sel = POS_LAST;
                     kind_in     = KIND_LAST;
                     state_in    = S_WALK;
                  end
               end
               OP_DEL_AT: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else if (stat.oob) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_BOUNDS;
                  end else begin
                     cmd.act  = ACT_WALK_INIT;
                     state_in = S_WALK;
                     if (stat.idx_zero) begin
                        kind_in = KIND_FIRST;
                     end else if (stat.idx_last) begin
                        cmd.pos_sel = POS_LAST;
                        kind_in     = KIND_LAST;
                     end else begin
                        cmd.pos_sel = POS_INDEX;
                        kind_in     = KIND_MID;
                     end
                  end
               end
               OP_READ: begin
                  if (stat.oob) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_BOUNDS;
                  end else begin
                     cmd.act     = ACT_WALK_INIT;
                     cmd.pos_sel = POS_INDEX;
                     kind_in     = KIND_READ;
                     state_in    = S_WALK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_APPEND_A: begin
            cmd.act  = ACT_APPEND_A;
            state_in = S_APPEND_B;
         end
         S_APPEND_B: begin
            cmd.act  = ACT_APPEND_B;
            state_in = S_DONE;
         end
         S_WALK: begin
            // one link per cycle; the previous slot is kept behind the cursor for unlinking
            if (stat.walk_zero) begin
               state_in = S_FETCH;
            end else begin
               cmd.act = ACT_WALK_STEP;
               if (stat.walk_last) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cmd.act  = ACT_FETCH;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.act = ACT_LOAD;
            if (kind_ff == KIND_READ) begin
               state_in = S_DONE;
            end else if (kind_ff == KIND_MID || stat.multi) begin
               state_in = S_FIX;
            end else begin
               state_in = S_RELEASE;
            end
         end
         S_FIX: begin
            case (kind_ff)
               KIND_FIRST: cmd.act = ACT_FIX_FIRST;
               KIND_LAST:  cmd.act = ACT_FIX_LAST;
               default:    cmd.act = ACT_FIX_MID;
            endcase
            state_in = S_RELEASE;
         end
         S_RELEASE: begin
            cmd.act  = ACT_RELEASE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_READ;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== src/blle_checker.sv =====
// port-level checks for the bounded linked list engine, bound to the top level
// depends on blle_pkg and bounded_linked_list_engine_defines.svh
`timescale 1ns / 1ps
`include "bounded_linked_list_engine_defines.svh"

module blle_checker import blle_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [OP_W-1:0]       req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [ST_W-1:0]       rsp_tuser
);

   `BLLE_ASSERT_SAME(a_error_value_zero, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata[VAL_W-1:0] == '0, "error beat carries a value")
   `BLLE_ASSERT_SAME(a_full_at_capacity, rsp_tvalid && rsp_tuser == ST_FULL, rsp_tdata[VAL_W+LEN_W-1:VAL_W] == LEN_W'(CAPACITY), "full reported below capacity")
   `BLLE_ASSERT_SAME(a_empty_zero_length, rsp_tvalid && rsp_tuser == ST_EMPTY, rsp_tdata[VAL_W+LEN_W-1:VAL_W] == '0, "empty reported with entries")
   `BLLE_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second beat taken while busy")
   `BLLE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

endmodule

bind bounded_linked_list_engine blle_checker #(.CAPACITY(CAPACITY)) u_blle_checker (.*);

// ===== verif/tb_bounded_linked_list_engine.sv =====
// self-checking testbench for bounded_linked_list_engine: a queue-based list predictor
// is checked against every result beat; depends on blle_pkg and the engine rtl only
`timescale 1ns / 1ps

module tb_bounded_linked_list_engine;
   import blle_pkg::*;

   localparam int LIST_CAP      = 256;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 300;
   localparam int DRAIN_LIMIT   = 50000;

   // op codes the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam logic [VAL_W-1:0] VAL_MOST_NEG = 32'h8000_0000;
   localparam logic [VAL_W-1:0] VAL_MOST_POS = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [VAL_W-1:0] entry_value;
      logic [LEN_W-1:0] length;
   } list_result_type;

   typedef enum logic [1:0] {
      RX_OPEN   = 2'd0,
      RX_HALF   = 2'd1,
      RX_SPARSE = 2'd2
   } rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // value[31:0], index[39:32]
   logic [OP_W-1:0]       req_tuser = '0;   // op[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // entry_value[31:0], length[40:32], zero pad
   logic [ST_W-1:0]       rsp_tuser;        // status[1:0]

   // predictor state: the list contents in order, head first
   logic [VAL_W-1:0] list_model[$];
   list_result_type  pending_results[$];

   int error_count   = 0;
   int beats_sent    = 0;
   int beats_checked = 0;
   int appends_done  = 0;
   int full_hits     = 0;
   int empty_hits    = 0;
   int bounds_hits   = 0;
   int peak_length   = 0;

   // sender burst control
   int burst_left = 4;
   bit gapless    = 1'b0;

   // receiver hold request from the test sequence
   bit hold_req = 1'b0;

   bounded_linked_list_engine #(
      .CAPACITY(LIST_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("timeout with %0d results still pending", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic predict_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                                  input logic [IDX_W-1:0] index, output list_result_type res);
      int len;
      len = list_model.size();
      res.status      = ST_OK;
      res.entry_value = '0;
      case (op)
         OP_APPEND: begin
            if (len >= LIST_CAP) begin
               res.status = ST_FULL;
            end else begin
               list_model.push_back(value);
               appends_done++;
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST: begin
            if (len == 0) begin
               res.status = ST_EMPTY;
            end else if (op == OP_DEL_FIRST) begin
               res.entry_value = list_model.pop_front();
            end else begin
               res.entry_value = list_model.pop_back();
            end
         end
         OP_DEL_AT: begin
            // empty wins over out of bounds
            if (len == 0) begin
               res.status = ST_EMPTY;
            end else if (int'(index) >= len) begin
               res.status = ST_BOUNDS;
            end else begin
               res.entry_value = list_model[index];
               list_model.delete(int'(index));
            end
         end
         OP_READ: begin
            if (int'(index) >= len) begin
               res.status = ST_BOUNDS;
            end else begin
               res.entry_value = list_model[index];
            end
         end
         default: ;
      endcase
      res.length = LEN_W'(list_model.size());
      case (res.status)
         ST_FULL:   full_hits++;
         ST_EMPTY:  empty_hits++;
         ST_BOUNDS: bounds_hits++;
         default: ;
      endcase
      if (list_model.size() > peak_length) peak_length = list_model.size();
   endtask

   // offer one beat, wait for acceptance, then maybe leave a gap
   task automatic send_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                               input logic [IDX_W-1:0] index);
      list_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {index, value};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_list_op(op, value, index, predicted);
      pending_results.push_back(predicted);
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && !gapless) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MOST_NEG;
         1:       return VAL_MOST_POS;
         2:       return VAL_ALL_ONES;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      int len;
      len = list_model.size();
      if (len > 0 && $urandom_range(0, 9) < 8) return IDX_W'($urandom_range(0, len - 1));
      return IDX_W'($urandom_range(0, 255));
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin : rsp_side
      list_result_type want;
      rx_mode_type     mode;
      int              mode_left;
      int              hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         mode       = RX_OPEN;
         mode_left  = 64;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (pending_results.size() == 0) begin
               $error("result beat with no expectation waiting: status %0d value %0d",
                      rsp_tuser, $signed(rsp_tdata[VAL_W-1:0]));
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[VAL_W-1:0] !== want.entry_value) begin
                  $error("entry_value: expected %0d, actual %0d",
                         $signed(want.entry_value), $signed(rsp_tdata[VAL_W-1:0]));
                  error_count++;
               end
               if (rsp_tdata[VAL_W +: LEN_W] !== want.length) begin
                  $error("length: expected %0d, actual %0d", want.length,
                         rsp_tdata[VAL_W +: LEN_W]);
                  error_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:VAL_W+LEN_W] !== '0) begin
                  $error("pad: expected 0, actual %0h", rsp_tdata[RSP_DATA_W-1:VAL_W+LEN_W]);
                  error_count++;
               end
            end
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // empty-list errors, unused codes, extreme values and each delete flavor
   task automatic test_directed_cases();
      send_list_op(OP_DEL_FIRST, $urandom(), 8'd0);
      send_list_op(OP_DEL_LAST, $urandom(), 8'd0);
      send_list_op(OP_DEL_AT, $urandom(), 8'd0);
      send_list_op(OP_DEL_AT, $urandom(), 8'd255);
      send_list_op(OP_READ, $urandom(), 8'd0);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
         send_list_op(OP_W'(op), $urandom(), IDX_W'($urandom()));
      send_list_op(OP_APPEND, VAL_MOST_NEG, 8'd255);
      send_list_op(OP_APPEND, VAL_MOST_POS, 8'd0);
      send_list_op(OP_APPEND, '0, 8'd0);
      send_list_op(OP_APPEND, VAL_ALL_ONES, 8'd0);
      send_list_op(OP_APPEND, 32'h5A5A_5A5A, 8'd0);
      send_list_op(OP_READ, '0, 8'd0);
      send_list_op(OP_READ, '0, 8'd4);
      send_list_op(OP_READ, '0, 8'd5);
      send_list_op(OP_READ, '0, 8'd255);
      // middle, then last index, then index zero, then past the end
      send_list_op(OP_DEL_AT, '0, 8'd2);
      send_list_op(OP_DEL_AT, '0, 8'd3);
      send_list_op(OP_DEL_AT, '0, 8'd0);
      send_list_op(OP_DEL_AT, '0, 8'd2);
      send_list_op(OP_DEL_LAST, '0, 8'd0);
      send_list_op(OP_DEL_FIRST, '0, 8'd0);
      // single entry removed from either end
      send_list_op(OP_APPEND, 32'hC3C3_3C3C, 8'd0);
      send_list_op(OP_DEL_LAST, '0, 8'd0);
      send_list_op(OP_APPEND, 32'h0000_0001, 8'd0);
      send_list_op(OP_DEL_AT, '0, 8'd0);
   endtask

   // fill to capacity, hit the full case, reuse freed slots, drain to empty
   task automatic test_fill_and_drain();
      while (list_model.size() < LIST_CAP)
         send_list_op(OP_APPEND, rand_value(), IDX_W'($urandom()));
      send_list_op(OP_APPEND, rand_value(), 8'd0);
      send_list_op(OP_APPEND, rand_value(), 8'd0);
      send_list_op(OP_READ, '0, 8'd255);
      send_list_op(OP_READ, '0, 8'd128);
      send_list_op(OP_DEL_AT, '0, 8'd255);
      send_list_op(OP_APPEND, rand_value(), 8'd0);
      send_list_op(OP_DEL_AT, '0, 8'd0);
      send_list_op(OP_APPEND, rand_value(), 8'd0);
      send_list_op(OP_DEL_AT, '0, 8'd200);
      send_list_op(OP_APPEND, rand_value(), 8'd0);
      send_list_op(OP_READ, '0, 8'd255);
      while (list_model.size() > 0) begin
         case ($urandom_range(0, 4))
            0:       send_list_op(OP_DEL_FIRST, $urandom(), IDX_W'($urandom()));
            1:       send_list_op(OP_DEL_LAST, $urandom(), IDX_W'($urandom()));
            2:       send_list_op(OP_READ, $urandom(), rand_index());
            default: send_list_op(OP_DEL_AT, $urandom(), rand_index());
         endcase
      end
      send_list_op(OP_DEL_LAST, '0, 8'd0);
   endtask

   // receiver holds off while the sender keeps offering, so the input backs up
   task automatic test_output_backpressure();
      gapless  = 1'b1;
      hold_req = 1'b1;
      @(posedge clock);
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 2) send_list_op(OP_READ, $urandom(), rand_index());
         else            send_list_op(OP_APPEND, rand_value(), IDX_W'($urandom()));
      end
      gapless = 1'b0;
   endtask

   // mixed traffic around a moderate list length, with gapless stretches
   task automatic test_random_mix(input int count);
      int               len;
      int               pick;
      logic [OP_W-1:0]  op;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) gapless = ($urandom_range(0, 2) == 0);
         len  = list_model.size();
         pick = $urandom_range(0, 99);
         if (pick < 4)                           op = OP_W'($urandom_range(OP_UNUSED_LO,
                                                                           OP_UNUSED_HI));
         else if (pick < ((len < 24) ? 50 : 30)) op = OP_APPEND;
         else if (pick < 60)                     op = OP_READ;
         else if (pick < 70)                     op = OP_DEL_FIRST;
         else if (pick < 80)                     op = OP_DEL_LAST;
         else                                    op = OP_DEL_AT;
         send_list_op(op, rand_value(), rand_index());
      end
      gapless = 1'b0;
   endtask

   initial begin
      int drain_cycles;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_fill_and_drain();
      test_output_backpressure();
      test_random_mix(560);

      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end

      $display("sent %0d beats, checked %0d results; %0d appends, peak length %0d",
               beats_sent, beats_checked, appends_done, peak_length);
      $display("error statuses seen: %0d full, %0d empty, %0d out of bounds",
               full_hits, empty_hits, bounds_hits);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
